// ===== rtl/core/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// Depends on nothing; every other file of the block imports it.
package ple_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 9;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned CAPACITY_DEF = 256;

  // Stream beat widths; the data fields are padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned IN_TUSER_W  = OP_W;
  localparam int unsigned OUT_TDATA_W = 80;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MOVE   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_APPLY,
    ST_SWEEP
  } state_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_MOVE
  } cmd_kind_e;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    cmd_kind_e                 kind;
    logic signed [DATA_W-1:0]  ins_val;
    logic signed [DATA_W-1:0]  move_val;
  } cell_cmd_t;

  // One result beat; the last member sits in the lowest bits.
  typedef struct packed {
    logic                      rejected;
    logic                      maximum_valid;
    logic signed [DATA_W-1:0]  maximum;
    logic [POS_W-1:0]          count;
    logic                      read_valid;
    logic signed [DATA_W-1:0]  read_value;
  } result_t;

endpackage

// ===== rtl/core/ple_cell.sv =====
// One list cell: holds a single entry and takes part in the shift, maximum and
// read chains that run between neighboring cells. Depends on ple_pkg.
module ple_cell #(
  parameter int unsigned CW  = 9,
  parameter int unsigned IDX = 0
) (
  input  logic                                clk_i,
  input  ple_pkg::cell_cmd_t                  cmd_i,
  input  logic [CW-1:0]                       pos_i,
  input  logic [CW-1:0]                       cnt_i,
  input  logic signed [ple_pkg::DATA_W-1:0]   prev_val_i,
  input  logic signed [ple_pkg::DATA_W-1:0]   next_val_i,
  input  logic signed [ple_pkg::DATA_W-1:0]   next_max_i,
  input  logic signed [ple_pkg::DATA_W-1:0]   next_rd_i,
  output logic signed [ple_pkg::DATA_W-1:0]   val_o,
  output logic signed [ple_pkg::DATA_W-1:0]   max_o,
  output logic signed [ple_pkg::DATA_W-1:0]   rd_o
);
  import ple_pkg::*;

  localparam logic [CW-1:0] Idx     = CW'(IDX);
  localparam logic [CW:0]   IdxNext = (CW+1)'(IDX + 1);

  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] max_q, max_d;
  logic signed [DATA_W-1:0] rd_q, rd_d;
  logic                     next_occ;

  // Entry update: take the left neighbor on insert, the right one on remove or move.
  always_comb begin
    val_d = val_q;
    case (cmd_i.kind) inside
      CMD_INSERT: begin
        if (Idx == pos_i) begin
          val_d = cmd_i.ins_val;
        end else if (Idx > pos_i && Idx <= cnt_i) begin
          val_d = prev_val_i;
        end
      end
      CMD_REMOVE, CMD_MOVE: begin
        if (Idx >= pos_i && IdxNext < {1'b0, cnt_i}) begin
          val_d = next_val_i;
        end else if (cmd_i.kind == CMD_MOVE && IdxNext == {1'b0, cnt_i}) begin
          val_d = cmd_i.move_val;
        end
      end
      default: ;
    endcase
  end

  // Suffix maximum travels from the tail toward the head, one cell a clock.
  assign next_occ = IdxNext < {1'b0, cnt_i};

  always_comb begin
    max_d = val_q;
    if (next_occ && next_max_i > val_q) begin
      max_d = next_max_i;
    end
  end

  // The addressed entry travels toward the head on the read chain.
  assign rd_d = (Idx == pos_i) ? val_q : next_rd_i;

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    max_q <= max_d;
    rd_q  <= rd_d;
  end

  assign val_o = val_q;
  assign max_o = max_q;
  assign rd_o  = rd_q;

endmodule

// ===== rtl/core/ple_ctrl.sv =====
// Command sequencer of the positional list engine: stream handshakes, range
// checks, entry count, chain settling and the result register. Depends on ple_pkg.
module ple_ctrl #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [ple_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  logic [ple_pkg::IN_TUSER_W-1:0]      s_tuser_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [ple_pkg::OUT_TDATA_W-1:0]     m_tdata_o,
  output ple_pkg::cell_cmd_t                  cmd_o,
  output logic [CW-1:0]                       pos_o,
  output logic [CW-1:0]                       cnt_o,
  input  logic signed [ple_pkg::DATA_W-1:0]   rd_head_i,
  input  logic signed [ple_pkg::DATA_W-1:0]   max_head_i
);
  import ple_pkg::*;

  localparam int unsigned WW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  state_e                   state_q, state_d;
  logic [CW-1:0]            ctr_q, ctr_d;
  logic [CW-1:0]            count_q, count_d;
  op_e                      op_q;
  logic [CW-1:0]            pos_q;
  logic signed [DATA_W-1:0] ins_q;
  logic                     rej_q;
  logic                     m_tvalid_q;
  result_t                  result_q, result_d;

  op_e                      in_op;
  logic [POS_W-1:0]         in_pos;
  logic signed [DATA_W-1:0] in_val;
  logic                     accept;
  logic                     rej_in;
  logic                     settled;
  logic                     out_free;
  logic                     out_load;

  // Input beat unpacking and range checks against the current count.
  assign in_op  = op_e'(s_tuser_i);
  assign in_pos = s_tdata_i[POS_W-1:0];
  assign in_val = s_tdata_i[POS_W +: DATA_W];

  always_comb begin
    if (in_op == OP_INSERT) begin
      rej_in = (count_q == CapCount) || (WW'(in_pos) > WW'(count_q));
    end else begin
      rej_in = WW'(in_pos) >= WW'(count_q);
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign settled    = (ctr_q == count_q);
  assign out_free   = !m_tvalid_q || m_tready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_op == OP_MOVE && !rej_in) ? ST_FETCH : ST_APPLY;
        end
      end
      ST_FETCH: begin
        if (settled) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_SWEEP;
      ST_SWEEP: begin
        if (settled && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: cell command, count update, settle counter.
  always_comb begin
    cmd_o          = '0;
    cmd_o.kind     = CMD_NONE;
    cmd_o.ins_val  = ins_q;
    cmd_o.move_val = rd_head_i;
    count_d        = count_q;
    ctr_d          = '0;
    out_load       = 1'b0;
    unique case (state_q) inside
      ST_FETCH, ST_SWEEP: begin
        ctr_d    = settled ? ctr_q : ctr_q + 1'b1;
        out_load = (state_q == ST_SWEEP) && settled && out_free;
      end
      ST_APPLY: begin
        if (!rej_q) begin
          unique case (op_q)
            OP_INSERT: begin
              cmd_o.kind = CMD_INSERT;
              count_d    = count_q + 1'b1;
            end
            OP_REMOVE: begin
              cmd_o.kind = CMD_REMOVE;
              count_d    = count_q - 1'b1;
            end
            OP_MOVE:   cmd_o.kind = CMD_MOVE;
            OP_READ:   cmd_o.kind = CMD_NONE;
            default:   cmd_o.kind = CMD_NONE;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign pos_o = pos_q;
  assign cnt_o = count_q;

  // Result assembly from the heads of the read and maximum chains.
  always_comb begin
    result_d.read_valid    = (op_q == OP_READ) && !rej_q;
    result_d.read_value    = result_d.read_valid ? rd_head_i : '0;
    result_d.count         = POS_W'(count_q);
    result_d.maximum_valid = (count_q != '0);
    result_d.maximum       = result_d.maximum_valid ? max_head_i : '0;
    result_d.rejected      = rej_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ctr_q      <= '0;
      count_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      count_q <= count_d;
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_op;
      pos_q <= CW'(in_pos);
      ins_q <= in_val;
      rej_q <= rej_in;
    end
    if (out_load) begin
      result_q <= result_d;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = OUT_TDATA_W'(result_q);

  // The list never grows past its capacity.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount)
    else $error("entry count above capacity");

  // The count moves only on the apply cycle.
  a_count_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_APPLY) |=> $stable(count_q))
    else $error("entry count changed outside apply");

  // Only an accepted move fetches the moved entry.
  a_fetch_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> (!rej_q && op_q == OP_MOVE))
    else $error("fetch without a valid move");

  // A new result beat appears only at the end of the settle sweep.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> ($past(state_q) == ST_SWEEP))
    else $error("result raised outside sweep");

endmodule

// ===== rtl/core/positional_list_engine_unit.sv =====
// Top level of the positional list engine: a row of list cells and the
// command sequencer. Depends on ple_pkg, ple_cell and ple_ctrl.
//
// The list sits in a row of CAPACITY cells, head in cell 0. Each command beat
// yields one result beat. Insert, remove and move shift every affected cell
// together in the apply state; the list maximum and the addressed entry then
// travel toward the head one cell per clock. A move first fetches the moved
// entry over the read chain. One command is in flight at a time; a finished
// result waits in the output register while the next command is accepted,
// and that command holds before its result until the waiting beat is taken.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // position [8:0], value [40:9], zero pad [47:41]
  input  logic [ple_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  // operation [1:0]
  input  logic [ple_pkg::IN_TUSER_W-1:0]   s_tuser_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // read_value [31:0], read_valid [32], count [41:33], maximum [73:42],
  // maximum_valid [74], rejected [75], zero pad [79:76]
  output logic [ple_pkg::OUT_TDATA_W-1:0]  m_tdata_o
);
  import ple_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  cell_cmd_t                cmd;
  logic [CW-1:0]            pos;
  logic [CW-1:0]            cnt;
  logic signed [DATA_W-1:0] val_w [CAPACITY];
  logic signed [DATA_W-1:0] max_w [CAPACITY];
  logic signed [DATA_W-1:0] rd_w  [CAPACITY];

  // Sequencer.
  ple_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .cmd_o      (cmd),
    .pos_o      (pos),
    .cnt_o      (cnt),
    .rd_head_i  (rd_w[0]),
    .max_head_i (max_w[0])
  );

  // Row of cells; the ends see zero neighbors.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [DATA_W-1:0] prev_val;
    logic signed [DATA_W-1:0] next_val;
    logic signed [DATA_W-1:0] next_max;
    logic signed [DATA_W-1:0] next_rd;

    if (k == 0) begin : g_head
      assign prev_val = '0;
    end else begin : g_body
      assign prev_val = val_w[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign next_val = '0;
      assign next_max = '0;
      assign next_rd  = '0;
    end else begin : g_link
      assign next_val = val_w[k+1];
      assign next_max = max_w[k+1];
      assign next_rd  = rd_w[k+1];
    end

    ple_cell #(
      .CW  (CW),
      .IDX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .pos_i      (pos),
      .cnt_i      (cnt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .next_max_i (next_max),
      .next_rd_i  (next_rd),
      .val_o      (val_w[k]),
      .max_o      (max_w[k]),
      .rd_o       (rd_w[k])
    );
  end

endmodule

// ===== test/positional_list_engine_unit_test.sv =====
// Self-checking testbench for positional_list_engine_unit: drives command beats,
// predicts every result beat with its own copy of the list and checks each field.
// Depends on ple_pkg and the engine RTL only.
module positional_list_engine_unit_test;
  import ple_pkg::*;

  localparam int unsigned LIST_CAP      = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 2 * LIST_CAP + 16;
  localparam int unsigned PAD_W         = IN_TDATA_W - POS_W - DATA_W;
  localparam int unsigned MAX_PRINTS    = 100;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_tvalid_i;
  logic                    s_tready_o;
  logic [IN_TDATA_W-1:0]   s_tdata_i;
  logic [IN_TUSER_W-1:0]   s_tuser_i;
  logic                    m_tvalid_o;
  logic                    m_tready_i;
  logic [OUT_TDATA_W-1:0]  m_tdata_o;

  // Shadow copy of the list, head at index 0.
  logic signed [DATA_W-1:0] list_words [LIST_CAP];
  int unsigned              list_len;

  // Result beats still owed by the engine, oldest first.
  result_t                  pending_results [$];

  int unsigned              error_count;
  int unsigned              cycle_count;
  int unsigned              gap_limit;
  bit                       hold_output;

  positional_list_engine_unit #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one command to the shadow list and return the beat it must produce.
  function automatic result_t apply_list_command(op_e op, logic [POS_W-1:0] pos,
                                                 logic signed [DATA_W-1:0] val);
    result_t                  res;
    logic signed [DATA_W-1:0] moved;
    logic signed [DATA_W-1:0] top;
    int unsigned              p;
    res = '0;
    p   = pos;
    if (op == OP_INSERT) begin
      if (list_len >= LIST_CAP || p > list_len) begin
        res.rejected = 1'b1;
      end else begin
        for (int unsigned k = list_len; k > p; k--) list_words[k] = list_words[k-1];
        list_words[p] = val;
        list_len++;
      end
    end else if (p >= list_len) begin
      // Every non-insert command needs an existing entry.
      res.rejected = 1'b1;
    end else begin
      case (op)
        OP_REMOVE: begin
          for (int unsigned k = p; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
        end
        OP_MOVE: begin
          // Moving the tail entry leaves the list as it is.
          moved = list_words[p];
          for (int unsigned k = p; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_words[list_len-1] = moved;
        end
        default: begin
          res.read_value = list_words[p];
          res.read_valid = 1'b1;
        end
      endcase
    end
    res.count = POS_W'(list_len);
    if (list_len != 0) begin
      top = list_words[0];
      for (int unsigned k = 1; k < list_len; k++) begin
        if (list_words[k] > top) top = list_words[k];
      end
      res.maximum       = top;
      res.maximum_valid = 1'b1;
    end
    return res;
  endfunction

  // Mixes extreme and near-zero words into otherwise random data.
  function automatic logic signed [DATA_W-1:0] random_word();
    logic signed [DATA_W-1:0] w;
    case ($urandom_range(9, 0))
      0:       w = 32'sh7FFF_FFFF;
      1:       w = 32'sh8000_0000;
      2:       w = DATA_W'($urandom_range(4, 0)) - 2;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Mostly a position the command can use; otherwise anywhere in the field.
  function automatic logic [POS_W-1:0] random_position(op_e op);
    int unsigned top_pos;
    top_pos = (op == OP_INSERT) ? list_len : list_len - 1;
    if ((op == OP_INSERT || list_len != 0) && $urandom_range(99, 0) < 88) begin
      return POS_W'($urandom_range(top_pos, 0));
    end
    return POS_W'($urandom_range((1 << POS_W) - 1, 0));
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic compare_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Compare one accepted result beat with the oldest prediction.
  task automatic check_result(logic [OUT_TDATA_W-1:0] beat);
    result_t got;
    result_t want;
    got = beat[$bits(result_t)-1:0];
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result beat %h with no command pending", beat));
    end else begin
      want = pending_results.pop_front();
      compare_field("read_value", got.read_value, want.read_value);
      compare_field("read_valid", DATA_W'(got.read_valid), DATA_W'(want.read_valid));
      compare_field("count", DATA_W'(got.count), DATA_W'(want.count));
      compare_field("maximum", got.maximum, want.maximum);
      compare_field("maximum_valid", DATA_W'(got.maximum_valid),
                    DATA_W'(want.maximum_valid));
      compare_field("rejected", DATA_W'(got.rejected), DATA_W'(want.rejected));
    end
  endtask

  // Offer one command beat after a random gap and predict it once accepted.
  task automatic send_command(op_e op, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = $urandom_range(gap_limit, 0);
    @(negedge clk_i);
    if (gap != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {{PAD_W{1'b0}}, val, pos};
    s_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    pending_results.push_back(apply_list_command(op, pos, val));
  endtask

  // Stop offering beats and wait for every owed result.
  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Rejections on an empty list, value extremes, insert, remove and move at head,
  // middle and tail, reads at head and tail, out-of-range positions and the tail move.
  task automatic test_directed_commands();
    send_command(OP_READ,   9'd0,   32'sd5);
    send_command(OP_REMOVE, 9'd0,   32'sd0);
    send_command(OP_MOVE,   9'd0,   32'sd0);
    send_command(OP_INSERT, 9'd1,   32'sd7);
    send_command(OP_INSERT, 9'd0,   32'sh7FFF_FFFF);
    send_command(OP_INSERT, 9'd0,   32'sh8000_0000);
    send_command(OP_INSERT, 9'd2,   -32'sd1);
    send_command(OP_INSERT, 9'd1,   32'sd0);
    send_command(OP_READ,   9'd3,   32'sd0);
    send_command(OP_READ,   9'd4,   32'sd0);
    send_command(OP_READ,   9'd511, -32'sd1);
    send_command(OP_INSERT, 9'd256, 32'sd9);
    send_command(OP_MOVE,   9'd3,   32'sd0);
    send_command(OP_MOVE,   9'd0,   32'sd0);
    send_command(OP_READ,   9'd3,   32'sd0);
    send_command(OP_REMOVE, 9'd1,   32'sd0);
    send_command(OP_INSERT, 9'd5,   32'sd1);
    send_command(OP_MOVE,   9'd1,   32'sd0);
    send_command(OP_REMOVE, 9'd2,   32'sd0);
    send_command(OP_REMOVE, 9'd0,   32'sd0);
    send_command(OP_READ,   9'd0,   32'sd0);
    send_command(OP_REMOVE, 9'd0,   32'sd0);
    send_command(OP_REMOVE, 9'd0,   32'sd0);
    wait_drained();
  endtask

  // Fill the list to capacity, poke it while full, then drain it again.
  task automatic test_fill_to_capacity();
    gap_limit = 0;
    while (list_len < LIST_CAP) begin
      if (list_len == LIST_CAP / 2) gap_limit = 8;
      send_command(OP_INSERT, POS_W'($urandom_range(list_len, 0)), random_word());
    end
    send_command(OP_INSERT, 9'd0, random_word());
    send_command(OP_INSERT, POS_W'(LIST_CAP), random_word());
    send_command(OP_READ,   POS_W'(LIST_CAP - 1), 32'sd0);
    send_command(OP_READ,   POS_W'(LIST_CAP), 32'sd0);
    send_command(OP_MOVE,   POS_W'(LIST_CAP - 1), 32'sd0);
    send_command(OP_MOVE,   9'd0, 32'sd0);
    send_command(OP_MOVE,   POS_W'(LIST_CAP / 2), 32'sd0);
    send_command(OP_REMOVE, POS_W'(LIST_CAP), 32'sd0);
    gap_limit = 0;
    while (list_len > 0) begin
      if (list_len == LIST_CAP / 2) gap_limit = 8;
      send_command(OP_REMOVE, POS_W'($urandom_range(list_len - 1, 0)), 32'sd0);
    end
    send_command(OP_READ, 9'd0, 32'sd0);
    wait_drained();
  endtask

  // Hold the result side off while beats keep coming so the input stalls.
  task automatic test_output_backpressure();
    op_e op;
    hold_output = 1'b1;
    gap_limit   = 0;
    for (int unsigned i = 0; i < 14; i++) begin
      op = (i < 8) ? OP_INSERT : op_e'($urandom_range(3, 0));
      send_command(op, random_position(op), random_word());
    end
    gap_limit = 8;
    wait_drained();
  endtask

  // Random traffic that keeps the list length near a wandering target.
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned target;
    int unsigned roll;
    op_e         op;
    target = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        target    = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 40)
                                                : $urandom_range(24, 0);
        gap_limit = ($urandom_range(3, 0) == 0) ? 0 : 8;
      end
      roll = $urandom_range(99, 0);
      if (list_len < target) begin
        op = (roll < 55) ? OP_INSERT : (roll < 65) ? OP_REMOVE
           : (roll < 80) ? OP_MOVE : OP_READ;
      end else begin
        op = (roll < 15) ? OP_INSERT : (roll < 55) ? OP_REMOVE
           : (roll < 75) ? OP_MOVE : OP_READ;
      end
      send_command(op, random_position(op), random_word());
    end
    gap_limit = 8;
    wait_drained();
  endtask

  // Result side: random ready gaps, one long hold on request, check each beat.
  initial begin : result_sink
    int unsigned gap;
    m_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        m_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_output = 1'b0;
      end else begin
        gap = $urandom_range(gap_limit, 0);
        if (gap != 0) begin
          m_tready_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      m_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid_o) @(posedge clk_i);
      check_result(m_tdata_o);
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Reset once, run each test in turn, then give the verdict.
  initial begin
    rst_ni      = 1'b0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    s_tuser_i   = OP_INSERT;
    list_len    = 0;
    error_count = 0;
    gap_limit   = 8;
    hold_output = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_commands();
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_traffic(320);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
